// ----- rtl/core/sgm_path_cost_aggregation_top_defines.svh -----
// assertion macros for the sgm path cost aggregation block
// used by sgm_path_cost_aggregation_top; depends on a clock and reset in scope
`ifndef SGM_PATH_COST_AGGREGATION_TOP_DEFINES_SVH
`define SGM_PATH_COST_AGGREGATION_TOP_DEFINES_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define SGM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define SGM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/sgm_pca_pkg.sv -----
// shared types, constants and helpers for the sgm path cost aggregation block
// no dependencies
`timescale 1ns / 1ps

package sgm_pca_pkg;

   // disparity storage depth and derived widths
   localparam int MAX_DISP  = 64;
   localparam int DISP_W    = (MAX_DISP > 2) ? $clog2(MAX_DISP) : 1;
   localparam int COUNT_W   = DISP_W + 1;

   // field widths
   localparam int COST_W    = 8;
   localparam int INTEN_W   = 8;
   localparam int PATH_W    = 13;
   localparam int DFIELD_W  = 6;
   localparam int P1_W      = 8;
   localparam int P2_W      = 12;
   localparam int CNT_CFG_W = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 12;

   // internal widths
   localparam int SUM_W     = PATH_W + 1;
   localparam int ACC_W     = PATH_W + 2;
   localparam int DEN_W     = INTEN_W + 1;
   localparam int DSTEP_W   = $clog2(P2_W);
   localparam int WIDE_W    = DISP_W + DFIELD_W;

   localparam logic [PATH_W-1:0] PATH_MAX = {PATH_W{1'b1}};

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_P1        = 2'd0,
      CSR_P2_BASE   = 2'd1,
      CSR_DISP_CNT  = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_index_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_BEST,
      ST_FINISH
   } state_type;

   // divider request and response
   typedef struct packed {
      logic             start;
      logic [P2_W-1:0]  numer;
      logic [DEN_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [P2_W-1:0] quot;
   } div_rsp_type;

   // counter to result field, zero-extended or truncated
   function automatic logic [DFIELD_W-1:0] disp_field(input logic [DISP_W-1:0] d);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(d);
      return wide[DFIELD_W-1:0];
   endfunction

endpackage

// ----- rtl/core/sgm_pca_div.sv -----
// restoring divider for the intensity-adaptive jump penalty, one quotient bit a cycle
// depends on sgm_pca_pkg
`timescale 1ns / 1ps

module sgm_pca_div (
   input  logic                      clock,
   input  logic                      reset,
   input  sgm_pca_pkg::div_req_type  div_req,
   output sgm_pca_pkg::div_rsp_type  div_rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [sgm_pca_pkg::DSTEP_W-1:0]     step_ff, step_in;
   logic [sgm_pca_pkg::DEN_W-1:0]       rem_ff, rem_in;
   logic [sgm_pca_pkg::P2_W-1:0]        quot_ff, quot_in;
   logic [sgm_pca_pkg::DEN_W-1:0]       den_ff, den_in;
   logic [sgm_pca_pkg::DEN_W:0]         trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quot_ff[sgm_pca_pkg::P2_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quot_in = div_req.numer;
         den_in  = div_req.denom;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract where it fits
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = sgm_pca_pkg::DEN_W'(trial - {1'b0, den_ff});
            quot_in = {quot_ff[sgm_pca_pkg::P2_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[sgm_pca_pkg::DEN_W-1:0];
            quot_in = {quot_ff[sgm_pca_pkg::P2_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == sgm_pca_pkg::DSTEP_W'(sgm_pca_pkg::P2_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

// ----- rtl/core/sgm_path_cost_aggregation_top.sv -----
// top level of the sgm path cost aggregation block: sequencer, path cost memory, datapath
// depends on sgm_pca_pkg, sgm_pca_div and sgm_path_cost_aggregation_top_defines.svh
`timescale 1ns / 1ps

// Semi-global matching aggregation along one scanline path. Costs arrive one beat per
// disparity, 0 up to disparity_count-1 for each pixel; each beat returns one path cost
// beat carrying its disparity and a pixel_done flag on the last disparity. The previous
// pixel's path costs live in a 64-entry synchronous memory, read at d and d+1 and written
// back at d. One item is in work at a time: a beat at disparities 1 and up passes through
// accept, memory read, minimum search, and subtract and write-back; the beat at disparity 0
// also runs the jump penalty divide first, a 12-bit quotient from a one-bit-per-cycle
// restoring divider, handed over through a register before the memory read. A finished
// beat waits in an output register while the next beat is accepted; a stalled receiver
// holds the write-back step until that register frees. Memory entries never written since
// reset read as undefined; the memory needs no clearing pass.
// Configuration writes land at once and are meant for idle periods between pixels.

module sgm_path_cost_aggregation_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // input cost beats
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [sgm_pca_pkg::COST_W-1:0]       req_match_cost,
   input  logic [sgm_pca_pkg::INTEN_W-1:0]      req_intensity,
   input  logic                                 req_row_start,
   // path cost beats
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [sgm_pca_pkg::PATH_W-1:0]       rsp_path_cost,
   output logic [sgm_pca_pkg::DFIELD_W-1:0]     rsp_disparity,
   output logic                                 rsp_pixel_done,
   // register writes
   input  logic                                 csr_we,
   input  logic [sgm_pca_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sgm_pca_pkg::CSR_DAT_W-1:0]    csr_wdata
);

`include "sgm_path_cost_aggregation_top_defines.svh"

   // configuration registers
   logic [sgm_pca_pkg::P1_W-1:0]       p1_ff;
   logic [sgm_pca_pkg::P2_W-1:0]       p2_base_ff;
   logic [sgm_pca_pkg::CNT_CFG_W-1:0]  disp_cnt_ff;

   // sequencer
   sgm_pca_pkg::state_type             state_ff, state_in;
   logic                               accept;
   logic                               load_out;
   logic                               first_disp;

   // per-path state
   logic [sgm_pca_pkg::DISP_W-1:0]     disp_ff, disp_in;
   logic [sgm_pca_pkg::PATH_W-1:0]     prev_min_ff, prev_min_in;
   logic [sgm_pca_pkg::PATH_W-1:0]     run_min_ff, run_min_in;
   logic [sgm_pca_pkg::PATH_W-1:0]     held_lower_ff;
   logic [sgm_pca_pkg::INTEN_W-1:0]    prev_inten_ff;
   logic [sgm_pca_pkg::P2_W-1:0]       jump_pen_ff;
   logic                               start_ff, start_in;

   // item in work
   logic [sgm_pca_pkg::COST_W-1:0]     cost_ff;
   logic [sgm_pca_pkg::SUM_W-1:0]      best_ff, best_in;

   // path cost memory with registered reads
   logic [sgm_pca_pkg::PATH_W-1:0]     cost_mem [sgm_pca_pkg::MAX_DISP];
   logic [sgm_pca_pkg::PATH_W-1:0]     rd_here_ff;
   logic [sgm_pca_pkg::PATH_W-1:0]     rd_up_ff;
   logic [sgm_pca_pkg::DISP_W-1:0]     disp_up;

   // output register
   logic                               rsp_valid_ff;
   logic [sgm_pca_pkg::PATH_W-1:0]     rsp_cost_ff;
   logic [sgm_pca_pkg::DFIELD_W-1:0]   rsp_disp_ff;
   logic                               rsp_done_ff;

   // divider
   sgm_pca_pkg::div_req_type           div_req;
   sgm_pca_pkg::div_rsp_type           div_rsp;
   logic [sgm_pca_pkg::INTEN_W-1:0]    inten_diff;

   // datapath
   logic [sgm_pca_pkg::COUNT_W-1:0]    count_eff;
   logic                               last_disp;
   logic                               top_edge;
   logic [sgm_pca_pkg::SUM_W-1:0]      here_p, lower_p, upper_p, jump_p;
   logic [sgm_pca_pkg::SUM_W-1:0]      min_a, min_b;
   logic [sgm_pca_pkg::ACC_W-1:0]      acc;
   logic [sgm_pca_pkg::ACC_W-1:0]      acc_net;
   logic [sgm_pca_pkg::PATH_W-1:0]     result;

   // ---------------------------------------------------------------------------------
   // configuration: writes to an index past the list are dropped
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff       <= sgm_pca_pkg::P1_W'(10);
         p2_base_ff  <= sgm_pca_pkg::P2_W'(150);
         disp_cnt_ff <= sgm_pca_pkg::CNT_CFG_W'(64);
      end else if (csr_we) begin
         unique case (sgm_pca_pkg::csr_index_type'(csr_index))
            sgm_pca_pkg::CSR_P1:       p1_ff       <= csr_wdata[sgm_pca_pkg::P1_W-1:0];
            sgm_pca_pkg::CSR_P2_BASE:  p2_base_ff  <= csr_wdata[sgm_pca_pkg::P2_W-1:0];
            sgm_pca_pkg::CSR_DISP_CNT: disp_cnt_ff <= csr_wdata[sgm_pca_pkg::CNT_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // count in use: zero acts as one, clamp at the memory depth
   always_comb begin
      if (disp_cnt_ff == '0) begin
         count_eff = sgm_pca_pkg::COUNT_W'(1);
      end else if (32'(disp_cnt_ff) > sgm_pca_pkg::MAX_DISP) begin
         count_eff = sgm_pca_pkg::COUNT_W'(sgm_pca_pkg::MAX_DISP);
      end else begin
         count_eff = sgm_pca_pkg::COUNT_W'(disp_cnt_ff);
      end
   end

   // last disparity also when the count was lowered under the counter
   assign last_disp  = ({1'b0, disp_ff} + 1'b1) >= count_eff;
   assign top_edge   = disp_ff == sgm_pca_pkg::DISP_W'(sgm_pca_pkg::MAX_DISP - 1);
   assign first_disp = disp_ff == '0;

   // ---------------------------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sgm_pca_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = first_disp ? sgm_pca_pkg::ST_DIV : sgm_pca_pkg::ST_READ;
            end
         end
         sgm_pca_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               state_in = sgm_pca_pkg::ST_READ;
            end
         end
         sgm_pca_pkg::ST_READ:   state_in = sgm_pca_pkg::ST_BEST;
         sgm_pca_pkg::ST_BEST:   state_in = sgm_pca_pkg::ST_FINISH;
         sgm_pca_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = sgm_pca_pkg::ST_IDLE;
            end
         end
         default: state_in = sgm_pca_pkg::ST_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_ready = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         sgm_pca_pkg::ST_IDLE:   req_ready = 1'b1;
         sgm_pca_pkg::ST_FINISH: load_out  = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgm_pca_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // jump penalty: p2_base / (|intensity - previous| + 1), started on disparity 0
   // ---------------------------------------------------------------------------------
   assign inten_diff = (req_intensity > prev_inten_ff) ? req_intensity - prev_inten_ff
                                                       : prev_inten_ff - req_intensity;

   assign div_req.start = accept && first_disp;
   assign div_req.numer = p2_base_ff;
   assign div_req.denom = {1'b0, inten_diff} + 1'b1;

   sgm_pca_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------------------------------------------------------------------------
   // path cost memory: reads follow the counter every cycle, write at pixel step end
   // ---------------------------------------------------------------------------------
   assign disp_up = disp_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (load_out) begin
         cost_mem[disp_ff] <= result;
      end
      rd_here_ff <= cost_mem[disp_ff];
      rd_up_ff   <= cost_mem[disp_up];
   end

   // ---------------------------------------------------------------------------------
   // minimum of the four candidates, registered
   // ---------------------------------------------------------------------------------
   always_comb begin
      here_p  = sgm_pca_pkg::SUM_W'(rd_here_ff);
      lower_p = (first_disp ? sgm_pca_pkg::SUM_W'(rd_here_ff)
                            : sgm_pca_pkg::SUM_W'(held_lower_ff))
                + sgm_pca_pkg::SUM_W'(p1_ff);
      // missing upper neighbor at the top of the range
      upper_p = ((last_disp || top_edge) ? sgm_pca_pkg::SUM_W'(rd_here_ff)
                                         : sgm_pca_pkg::SUM_W'(rd_up_ff))
                + sgm_pca_pkg::SUM_W'(p1_ff);
      jump_p  = sgm_pca_pkg::SUM_W'(prev_min_ff) + sgm_pca_pkg::SUM_W'(jump_pen_ff);
      min_a   = (here_p < lower_p) ? here_p : lower_p;
      min_b   = (upper_p < jump_p) ? upper_p : jump_p;
      best_in = (min_a < min_b) ? min_a : min_b;
   end

   // ---------------------------------------------------------------------------------
   // cost plus best minus previous minimum, clamped to the path cost range; on a path start, the cost alone
   // ---------------------------------------------------------------------------------
   always_comb begin
      acc     = sgm_pca_pkg::ACC_W'(cost_ff) + sgm_pca_pkg::ACC_W'(best_ff);
      acc_net = acc - sgm_pca_pkg::ACC_W'(prev_min_ff);
      priority if (start_ff) begin
         result = sgm_pca_pkg::PATH_W'(cost_ff);
      end else if (acc < sgm_pca_pkg::ACC_W'(prev_min_ff)) begin
         result = '0;
      end else if (acc_net > sgm_pca_pkg::ACC_W'(sgm_pca_pkg::PATH_MAX)) begin
         result = sgm_pca_pkg::PATH_MAX;
      end else begin
         result = acc_net[sgm_pca_pkg::PATH_W-1:0];
      end
   end

   // ---------------------------------------------------------------------------------
   // per-path state update
   // ---------------------------------------------------------------------------------
   always_comb begin
      disp_in     = disp_ff;
      prev_min_in = prev_min_ff;
      run_min_in  = run_min_ff;
      start_in    = start_ff;
      if (accept && first_disp) begin
         start_in = start_ff | req_row_start;
      end
      if (load_out) begin
         if (last_disp) begin
            // pixel end: its minimum becomes the reference for the next pixel
            prev_min_in = (result < run_min_ff) ? result : run_min_ff;
            run_min_in  = sgm_pca_pkg::PATH_MAX;
            start_in    = 1'b0;
            disp_in     = '0;
         end else begin
            run_min_in  = (result < run_min_ff) ? result : run_min_ff;
            disp_in     = disp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_ff       <= '0;
         prev_min_ff   <= '0;
         run_min_ff    <= sgm_pca_pkg::PATH_MAX;
         held_lower_ff <= '0;
         prev_inten_ff <= '0;
         jump_pen_ff   <= '0;
         start_ff      <= 1'b1;
      end else begin
         disp_ff     <= disp_in;
         prev_min_ff <= prev_min_in;
         run_min_ff  <= run_min_in;
         start_ff    <= start_in;
         if (accept && first_disp) begin
            prev_inten_ff <= req_intensity;
         end
         if (div_rsp.done) begin
            jump_pen_ff <= div_rsp.quot;
         end
         // old cost at d is the lower neighbor of the next disparity
         if (load_out) begin
            held_lower_ff <= rd_here_ff;
         end
      end
   end

   // item payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         cost_ff <= req_match_cost;
      end
      if (state_ff == sgm_pca_pkg::ST_BEST) begin
         best_ff <= best_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // output register: holds a finished beat while the next one is taken
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_out) begin
         rsp_cost_ff <= result;
         rsp_disp_ff <= sgm_pca_pkg::disp_field(disp_ff);
         rsp_done_ff <= last_disp;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_cost  = rsp_cost_ff;
   assign rsp_disparity  = rsp_disp_ff;
   assign rsp_pixel_done = rsp_done_ff;

   // ---------------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------------
   // the counter wraps to disparity 0 right after a pixel's last beat is produced
   `SGM_ASSERT_NEXT(a_wrap_after_last, load_out && last_disp, disp_ff == '0, "no pixel wrap")
   // a divide result only arrives while the sequencer waits for it
   `SGM_ASSERT_NOW(a_div_done_in_wait, div_rsp.done, state_ff == sgm_pca_pkg::ST_DIV, "stray div")
   // beats past disparity 0 skip the divide and go straight to the memory read
   `SGM_ASSERT_NEXT(a_skip_divide, accept && !first_disp, state_ff == sgm_pca_pkg::ST_READ, "div")

endmodule

// ----- verif/sgm_path_cost_aggregation_checker.sv -----
`timescale 1ns / 1ps
// checker for the sgm path cost aggregation block: predicts every path cost beat and compares
// depends on sgm_pca_pkg; watches the ports of sgm_path_cost_aggregation_top

module sgm_path_cost_aggregation_checker
   import sgm_pca_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [COST_W-1:0]    req_match_cost,
   input  logic [INTEN_W-1:0]   req_intensity,
   input  logic                 req_row_start,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [PATH_W-1:0]    rsp_path_cost,
   input  logic [DFIELD_W-1:0]  rsp_disparity,
   input  logic                 rsp_pixel_done,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output int                   mismatch_count,
   output int                   pending_count
);

   typedef struct packed {
      logic [PATH_W-1:0]   path_cost;
      logic [DFIELD_W-1:0] disparity;
      logic                pixel_done;
   } path_result_type;

   // register copies
   logic [P1_W-1:0]      p1_penalty;
   logic [P2_W-1:0]      p2_base;
   logic [CNT_CFG_W-1:0] disp_count;

   // path state of the previous and current pixel
   logic [PATH_W-1:0]    prev_costs [MAX_DISP];
   logic [PATH_W-1:0]    prev_min;
   logic [PATH_W-1:0]    run_min;
   logic [PATH_W-1:0]    held_lower;
   logic [INTEN_W-1:0]   prev_inten;
   logic [DISP_W-1:0]    disp_ctr;
   logic [P2_W-1:0]      jump_penalty;
   logic                 start_latched;

   path_result_type      path_cost_q[$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   task automatic report_mismatch(input string field, input int expected, input int actual);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
   endtask

   // one cost beat in, one path cost out
   task automatic predict_path_cost(input logic [COST_W-1:0] cost,
                                    input logic [INTEN_W-1:0] inten,
                                    input logic rstart);
      int              active;
      int              d;
      int              diff;
      int              old_here;
      int              lower;
      int              upper;
      int              best;
      int              value;
      int              step_pen;
      int              mp;
      logic            last;
      path_result_type res;
      if (disp_count == 0)
         active = 1;
      else if (disp_count > MAX_DISP)
         active = MAX_DISP;
      else
         active = disp_count;
      d    = disp_ctr;
      last = (d + 1 >= active);
      if (d == 0) begin
         diff = (inten > prev_inten) ? inten - prev_inten : prev_inten - inten;
         jump_penalty  = p2_base / (diff + 1);
         prev_inten    = inten;
         start_latched = start_latched | rstart;
      end
      old_here = prev_costs[d];
      if (start_latched) begin
         value = cost;
      end else begin
         step_pen = p1_penalty;
         mp       = prev_min;
         // edges fall back on the cost at d itself
         lower = (d == 0) ? old_here + step_pen : held_lower + step_pen;
         if (last || d + 1 >= MAX_DISP)
            upper = old_here + step_pen;
         else
            upper = prev_costs[d + 1] + step_pen;
         best = old_here;
         if (lower < best) best = lower;
         if (upper < best) best = upper;
         if (mp + jump_penalty < best) best = mp + jump_penalty;
         value = cost + best - mp;
         if (value < 0) value = 0;
         if (value > PATH_MAX) value = PATH_MAX;
      end
      held_lower     = old_here;
      prev_costs[d]  = value;
      if (value < run_min) run_min = value;
      res.path_cost  = value;
      res.disparity  = d;
      res.pixel_done = last;
      path_cost_q.push_back(res);
      if (last) begin
         prev_min      = run_min;
         run_min       = PATH_MAX;
         start_latched = 1'b0;
         disp_ctr      = '0;
      end else begin
         disp_ctr = d + 1;
      end
   endtask

   always @(posedge clock) begin
      path_result_type exp_res;
      if (reset) begin
         p1_penalty    = 8'd10;
         p2_base       = 12'd150;
         disp_count    = 7'd64;
         foreach (prev_costs[i]) prev_costs[i] = '0;
         prev_min      = '0;
         run_min       = PATH_MAX;
         held_lower    = '0;
         prev_inten    = '0;
         disp_ctr      = '0;
         jump_penalty  = '0;
         start_latched = 1'b1;
         path_cost_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_P1:       p1_penalty = csr_wdata[P1_W-1:0];
               CSR_P2_BASE:  p2_base    = csr_wdata[P2_W-1:0];
               CSR_DISP_CNT: disp_count = csr_wdata[CNT_CFG_W-1:0];
               default:      ;
            endcase
         end
         if (req_valid && req_ready)
            predict_path_cost(req_match_cost, req_intensity, req_row_start);
         if (rsp_valid && rsp_ready) begin
            if (path_cost_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: path cost beat with none expected, actual cost %0d disparity %0d",
                        $time, rsp_path_cost, rsp_disparity);
            end else begin
               exp_res = path_cost_q.pop_front();
               if (rsp_path_cost !== exp_res.path_cost)
                  report_mismatch("path_cost", exp_res.path_cost, rsp_path_cost);
               if (rsp_disparity !== exp_res.disparity)
                  report_mismatch("disparity", exp_res.disparity, rsp_disparity);
               if (rsp_pixel_done !== exp_res.pixel_done)
                  report_mismatch("pixel_done", exp_res.pixel_done, rsp_pixel_done);
            end
         end
      end
      pending_count = path_cost_q.size();
   end

endmodule

// ----- verif/sgm_path_cost_aggregation_top_test.sv -----
`timescale 1ns / 1ps
// testbench top for the sgm path cost aggregation block: stimulus, receiver stalls, verdict
// depends on sgm_pca_pkg, sgm_path_cost_aggregation_top and sgm_path_cost_aggregation_checker

module sgm_path_cost_aggregation_top_test;
   import sgm_pca_pkg::*;

   // how the receiver takes path cost beats in a given stretch
   typedef enum {READY_FULL, READY_COIN, READY_BURSTY} ready_mode_type;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic [COST_W-1:0]    req_match_cost = '0;
   logic [INTEN_W-1:0]   req_intensity  = '0;
   logic                 req_row_start  = 1'b0;
   logic                 rsp_ready      = 1'b0;
   logic                 csr_we         = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = '0;
   logic [CSR_DAT_W-1:0] csr_wdata      = '0;
   wire                  req_ready;
   wire                  rsp_valid;
   wire [PATH_W-1:0]     rsp_path_cost;
   wire [DFIELD_W-1:0]   rsp_disparity;
   wire                  rsp_pixel_done;
   int                   mismatch_count;
   int                   pending_count;

   // beat bookkeeping on both channels
   int sent_count  = 0;
   int got_count   = 0;
   int burst_left  = 0;
   int pixel_total = 0;
   int phase_total = 0;

   // sender's own view of where the block stands inside a pixel, so that a pixel that
   // would read path costs never written since reset is always sent as a path start
   int                   disp_pos     = 0;
   int                   stored_depth = 0;
   logic                 start_mirror = 1'b1;
   logic [CNT_CFG_W-1:0] cfg_count    = 7'd64;
   logic [INTEN_W-1:0]   pixel_inten  = '0;

   // receiver pattern state
   ready_mode_type ready_mode  = READY_FULL;
   int             mode_cycles = 0;
   int             stall_left  = 0;

   sgm_path_cost_aggregation_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_match_cost (req_match_cost),
      .req_intensity  (req_intensity),
      .req_row_start  (req_row_start),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_path_cost  (rsp_path_cost),
      .rsp_disparity  (rsp_disparity),
      .rsp_pixel_done (rsp_pixel_done),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   sgm_path_cost_aggregation_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_match_cost (req_match_cost),
      .req_intensity  (req_intensity),
      .req_row_start  (req_row_start),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_path_cost  (rsp_path_cost),
      .rsp_disparity  (rsp_disparity),
      .rsp_pixel_done (rsp_pixel_done),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop well past the slowest legal run
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // receiver: counts accepted beats and stalls in stretches of changing character
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) got_count <= got_count + 1;
      if (mode_cycles == 0) begin
         ready_mode  = ready_mode_type'($urandom_range(0, 2));
         mode_cycles = $urandom_range(64, 256);
      end else begin
         mode_cycles--;
      end
      case (ready_mode)
         READY_FULL: rsp_ready <= 1'b1;
         READY_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         default: begin
            // mostly ready, now and then a run of stalls
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
               stall_left = $urandom_range(1, 10);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   // disparity count as the block applies it
   function automatic int active_disparities();
      if (cfg_count == 0) return 1;
      if (cfg_count > MAX_DISP) return MAX_DISP;
      return cfg_count;
   endfunction

   // costs lean on the extremes now and then
   function automatic logic [COST_W-1:0] pick_cost();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return COST_W'($urandom);
      endcase
   endfunction

   // one register write, with write enable dropped again before the task returns
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DAT_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DISP_CNT) cfg_count = data[CNT_CFG_W-1:0];
      @(posedge clock);
   endtask

   // drop valid and hold off until every path cost beat sent for has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (got_count < sent_count);
   endtask

   // one cost beat; opens a random gap whenever a burst runs out
   task automatic send_beat(input logic [COST_W-1:0] cost, input logic [INTEN_W-1:0] inten,
                            input logic rstart);
      int   active;
      int   gap;
      logic start_bit;
      active    = active_disparities();
      start_bit = rstart;
      if (disp_pos == 0 && !start_mirror && active > stored_depth) start_bit = 1'b1;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_match_cost <= cost;
      req_intensity  <= inten;
      req_row_start  <= start_bit;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      // track the pixel position the way the block does
      if (disp_pos == 0) start_mirror = start_mirror | start_bit;
      if (disp_pos + 1 > stored_depth) stored_depth = disp_pos + 1;
      if (disp_pos + 1 >= active) begin
         disp_pos     = 0;
         start_mirror = 1'b0;
         pixel_total++;
      end else begin
         disp_pos++;
      end
   endtask

   // a whole pixel; a noisy one carries junk intensity and row_start past disparity 0
   task automatic send_pixel(input logic rstart, input logic noisy);
      int                 n;
      int                 d;
      logic [INTEN_W-1:0] inten;
      n = active_disparities();
      if ($urandom_range(0, 3) == 0)
         inten = INTEN_W'($urandom);
      else
         inten = pixel_inten + INTEN_W'($urandom_range(0, 16)) - INTEN_W'(8);
      pixel_inten = inten;
      for (d = 0; d < n; d++) begin
         if (d > 0 && noisy)
            send_beat(pick_cost(), INTEN_W'($urandom), 1'($urandom_range(0, 1)));
         else
            send_beat(pick_cost(), inten, (d == 0) ? rstart : 1'b0);
         // rare full drain in the middle of a pixel
         if ($urandom_range(0, 199) == 0) wait_idle();
      end
   endtask

   initial begin
      int                   phase_goal;
      logic [CNT_CFG_W-1:0] count_val;
      logic [P1_W-1:0]      p1_val;
      logic [P2_W-1:0]      p2_val;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: three disparities, steepest penalties
      write_reg(CSR_DISP_CNT, 12'd3);
      write_reg(CSR_P1, 12'd255);
      write_reg(CSR_P2_BASE, 12'd4095);
      write_reg(CSR_UNUSED, 12'hfff);
      // first pixel after reset is a path start even with row_start low;
      // intensity and row_start past disparity 0 must be ignored
      send_beat(8'd255, 8'd0, 1'b0);
      send_beat(8'd0, 8'd255, 1'b1);
      send_beat(8'd255, 8'd170, 1'b1);
      // full intensity swing from the last pixel
      send_beat(8'd0, 8'd255, 1'b0);
      send_beat(8'd255, 8'd255, 1'b0);
      send_beat(8'd0, 8'd255, 1'b0);
      // new path in mid-stream
      send_beat(8'd7, 8'd255, 1'b1);
      send_beat(8'd200, 8'd0, 1'b0);
      send_beat(8'd13, 8'd85, 1'b0);
      wait_idle();
      // zero penalties, and a count of zero behaves as one disparity
      write_reg(CSR_P1, 12'd0);
      write_reg(CSR_P2_BASE, 12'd0);
      write_reg(CSR_DISP_CNT, 12'd0);
      send_beat(8'd0, 8'd0, 1'b0);
      send_beat(8'd255, 8'd0, 1'b0);
      wait_idle();
      // start a six-disparity pixel, then cut it short by lowering the count
      write_reg(CSR_P1, 12'd3);
      write_reg(CSR_P2_BASE, 12'd100);
      write_reg(CSR_DISP_CNT, 12'd6);
      repeat (4) send_beat(8'd0, 8'd40, 1'b1);
      wait_idle();
      write_reg(CSR_DISP_CNT, 12'd2);
      send_beat(8'd0, 8'd40, 1'b0);
      // high minimum over two disparities, then widen again onto older low costs
      // so that the subtraction drops below zero and clamps
      send_beat(8'd255, 8'd40, 1'b0);
      send_beat(8'd255, 8'd40, 1'b0);
      wait_idle();
      write_reg(CSR_DISP_CNT, 12'd5);
      repeat (5) send_beat(8'd0, 8'd40, 1'b0);

      // random part: register settings change only with the block drained
      while (sent_count < 800) begin
         wait_idle();
         if (phase_total == 0)
            count_val = 7'd127;
         else if (phase_total == 1)
            count_val = 7'd64;
         else begin
            case ($urandom_range(0, 9))
               0:       count_val = 7'd0;
               1:       count_val = CNT_CFG_W'($urandom_range(64, 127));
               2:       count_val = CNT_CFG_W'($urandom_range(9, 40));
               default: count_val = CNT_CFG_W'($urandom_range(1, 8));
            endcase
         end
         case ($urandom_range(0, 5))
            0:       p1_val = '0;
            1:       p1_val = '1;
            2:       p1_val = P1_W'($urandom);
            default: p1_val = P1_W'($urandom_range(0, 20));
         endcase
         case ($urandom_range(0, 5))
            0:       p2_val = '0;
            1:       p2_val = '1;
            2:       p2_val = P2_W'($urandom);
            default: p2_val = P2_W'($urandom_range(0, 400));
         endcase
         // spare upper data bits carry junk the block must drop
         write_reg(CSR_DISP_CNT, {5'($urandom), count_val});
         write_reg(CSR_P1, {4'($urandom), p1_val});
         write_reg(CSR_P2_BASE, p2_val);
         if ($urandom_range(0, 3) == 0) write_reg(CSR_UNUSED, CSR_DAT_W'($urandom));
         phase_total++;
         phase_goal = sent_count + $urandom_range(30, 90);
         while (sent_count < phase_goal)
            send_pixel($urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0);
      end

      // drain, then give the pipeline time to show any stray beat
      wait_idle();
      repeat (50) @(posedge clock);
      $display("covered %0d cost beats in %0d pixels over %0d random register settings",
               sent_count, pixel_total, phase_total);
      if (pending_count != 0)
         $display("%0t: %0d path cost beats never arrived", $time, pending_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
